// File: hw/rtl/bsso_pkg.sv
// Shared types and constants for the band-limited saw/square oscillator.
// Used by the controller, datapath and top level.
// No dependencies.
package bsso_pkg;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAVEFORM_MODE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INCREMENT      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIPROCAL_INCREMENT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE            = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_WIDTH          = 3'd4;

  localparam logic [31:0] PULSE_WIDTH_RESET = 32'h8000_0000;

  // Datapath widths
  localparam int Q30_BITS   = 30;   // fractional phase in Q2.30 arithmetic
  localparam int ACC_BITS   = 40;   // signed Horner accumulator, Q.30
  localparam int MUL_A_BITS = 24;   // narrow multiplier operand
  localparam int MUL_B_BITS = 32;   // wide multiplier operand
  localparam int MUL_X_BITS = 40;   // full first operand, two passes
  localparam int PROD_BITS  = 72;
  localparam int D_BITS     = 32;   // D in Q2.30
  localparam int MAG_BITS   = 33;   // clamped |y|, up to 4.0 in Q.30

  // Q.30 constants
  localparam logic signed [ACC_BITS-1:0] ONE_Q30        = 40'sd1073741824;
  localparam logic signed [ACC_BITS-1:0] TWO_Q30        = 40'sd2147483648;
  localparam logic signed [ACC_BITS-1:0] THREE_Q30      = 40'sd3221225472;
  localparam logic signed [ACC_BITS-1:0] NINE_Q30       = 40'sd9663676416;
  localparam logic signed [ACC_BITS-1:0] HALF_Q30       = 40'sd536870912;
  localparam logic signed [ACC_BITS-1:0] THIRD_Q30      = 40'sd357913941;
  localparam logic signed [ACC_BITS-1:0] TWO_THIRDS_Q30 = 40'sd715827882;
  localparam logic [ACC_BITS-1:0]        Y_LIMIT        = 40'h01_0000_0000;

  typedef struct packed {
    logic        waveform_mode;
    logic [31:0] phase_increment;
    logic [31:0] reciprocal_increment;
    logic [15:0] amplitude;
    logic [31:0] pulse_width;
  } cfg_t;

  // Transition region of the sawtooth, by phase against the increment
  typedef enum logic [1:0] {
    RGN_LOW,    // p < inc
    RGN_MID,    // inc <= p < 2*inc
    RGN_HIGH,   // 2*inc <= p < 3*inc
    RGN_RAMP    // p >= 3*inc
  } region_t;

  typedef enum logic [1:0] {
    HSTEP_FIRST,
    HSTEP_SECOND,
    HSTEP_LAST
  } hstep_t;

  typedef enum logic [1:0] {
    JOB_D,
    JOB_HORNER,
    JOB_SCALE
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_TAKE_D,
    ST_H_SETUP,
    ST_TAKE_H,
    ST_OUT_SETUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic   advance;
    logic   classify;
    logic   mul_lo;
    logic   mul_hi;
    logic   take_d;
    logic   h_setup;
    logic   take_h;
    logic   out_setup;
    logic   emit;
    hstep_t h_step;
  } cmd_t;

  typedef struct packed {
    logic poly;       // sawtooth sample falls in a polynomial region
    logic out_busy;   // output register holds a sample not yet taken
  } sts_t;

endpackage

// File: hw/rtl/bsso_if.sv
// Valid/ready channel interfaces for tick requests and sample results.
// Depends on nothing.
interface bsso_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface bsso_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/bsso_ctrl.sv
// Sequencer: steps the datapath through phase update, D and three Horner
// steps (polynomial only) and output scaling. Depends on bsso_pkg.
module bsso_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_tick,
  output logic            in_ready,
  input  bsso_pkg::sts_t  sts,
  output bsso_pkg::cmd_t  cmd
);

  bsso_pkg::state_t state, state_next;
  bsso_pkg::job_t   job, job_next;
  bsso_pkg::hstep_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsso_pkg::ST_IDLE;
      job   <= bsso_pkg::JOB_D;
      step  <= bsso_pkg::HSTEP_FIRST;
    end else begin
      state <= state_next;
      job   <= job_next;
      step  <= step_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    job_next   = job;
    step_next  = step;
    case (state)
      bsso_pkg::ST_IDLE: begin
        if (in_valid && in_tick) begin
          state_next = bsso_pkg::ST_CLASSIFY;
        end
      end
      bsso_pkg::ST_CLASSIFY: begin
        if (sts.poly) begin
          state_next = bsso_pkg::ST_MUL_LO;
          job_next   = bsso_pkg::JOB_D;
        end else begin
          state_next = bsso_pkg::ST_OUT_SETUP;
        end
      end
      bsso_pkg::ST_MUL_LO: state_next = bsso_pkg::ST_MUL_HI;
      bsso_pkg::ST_MUL_HI: begin
        case (job)
          bsso_pkg::JOB_D:      state_next = bsso_pkg::ST_TAKE_D;
          bsso_pkg::JOB_HORNER: state_next = bsso_pkg::ST_TAKE_H;
          default:              state_next = bsso_pkg::ST_EMIT;
        endcase
      end
      bsso_pkg::ST_TAKE_D: begin
        state_next = bsso_pkg::ST_H_SETUP;
        step_next  = bsso_pkg::HSTEP_FIRST;
      end
      bsso_pkg::ST_H_SETUP: begin
        state_next = bsso_pkg::ST_MUL_LO;
        job_next   = bsso_pkg::JOB_HORNER;
      end
      bsso_pkg::ST_TAKE_H: begin
        case (step)
          bsso_pkg::HSTEP_FIRST: begin
            state_next = bsso_pkg::ST_H_SETUP;
            step_next  = bsso_pkg::HSTEP_SECOND;
          end
          bsso_pkg::HSTEP_SECOND: begin
            state_next = bsso_pkg::ST_H_SETUP;
            step_next  = bsso_pkg::HSTEP_LAST;
          end
          default: state_next = bsso_pkg::ST_OUT_SETUP;
        endcase
      end
      bsso_pkg::ST_OUT_SETUP: begin
        state_next = bsso_pkg::ST_MUL_LO;
        job_next   = bsso_pkg::JOB_SCALE;
      end
      bsso_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          state_next = bsso_pkg::ST_IDLE;
        end
      end
      default: state_next = bsso_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.h_step = step;
    in_ready   = 1'b0;
    case (state)
      bsso_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.advance = in_valid && in_tick;
      end
      bsso_pkg::ST_CLASSIFY:  cmd.classify  = 1'b1;
      bsso_pkg::ST_MUL_LO:    cmd.mul_lo    = 1'b1;
      bsso_pkg::ST_MUL_HI:    cmd.mul_hi    = 1'b1;
      bsso_pkg::ST_TAKE_D:    cmd.take_d    = 1'b1;
      bsso_pkg::ST_H_SETUP:   cmd.h_setup   = 1'b1;
      bsso_pkg::ST_TAKE_H:    cmd.take_h    = 1'b1;
      bsso_pkg::ST_OUT_SETUP: cmd.out_setup = 1'b1;
      bsso_pkg::ST_EMIT:      cmd.emit      = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/bsso_datapath.sv
// Datapath: phase accumulator, region select, one shared 24x32 multiplier
// used in two passes per product, Horner accumulator and output register.
// Depends on bsso_pkg.
module bsso_datapath #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bsso_pkg::cfg_t                cfg,
  input  bsso_pkg::cmd_t                cmd,
  output bsso_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int PB         = PHASE_BITS;
  localparam int AB         = bsso_pkg::ACC_BITS;
  localparam int AMP_BITS   = 49;                       // |y| * amplitude
  localparam int SCALE_BITS = AMP_BITS + SAMPLE_BITS - 1;
  localparam int R_BITS     = SCALE_BITS - 45;

  // ---- phase ----
  logic [PB-1:0]    phase;
  logic [PB+31:0]   inc_ext;
  logic [PB-1:0]    inc_pb;
  logic [PB:0]      phase_sum;
  logic [PB+29:0]   p_ext30;
  logic [PB+31:0]   p_ext32;
  logic [PB+29:0]   inc_ext30;
  logic [29:0]      p30;
  logic [31:0]      p32;
  logic [29:0]      t0;
  logic [PB:0]      inc2;
  logic [PB+1:0]    inc3;

  assign inc_ext   = {cfg.phase_increment, {PB{1'b0}}};
  assign inc_pb    = inc_ext[PB+31 -: PB];
  assign phase_sum = {1'b0, phase} + {1'b0, inc_pb};
  assign p_ext30   = {phase, 30'd0};
  assign p_ext32   = {phase, 32'd0};
  assign inc_ext30 = {inc_pb, 30'd0};
  assign p30       = p_ext30[PB+29 -: 30];
  assign p32       = p_ext32[PB+31 -: 32];
  assign t0        = inc_ext30[PB+29 -: 30];
  assign inc2      = {inc_pb, 1'b0};
  assign inc3      = {2'b00, inc_pb} + {1'b0, inc_pb, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.advance) begin
      if (cfg.waveform_mode) begin
        phase <= phase_sum[PB] ? '0 : phase_sum[PB-1:0];
      end else begin
        phase <= phase_sum[PB-1:0];
      end
    end
  end

  // ---- region and constants ----
  bsso_pkg::region_t region, region_r;
  logic signed [AB-1:0] t2, dc, ramp_val, c0, k_val;

  always_comb begin
    if ({2'b00, phase} >= inc3) begin
      region = bsso_pkg::RGN_RAMP;
    end else if ({1'b0, phase} >= inc2) begin
      region = bsso_pkg::RGN_HIGH;
    end else if (phase >= inc_pb) begin
      region = bsso_pkg::RGN_MID;
    end else begin
      region = bsso_pkg::RGN_LOW;
    end
  end

  assign t2       = {9'd0, t0, 1'b0};
  assign dc       = bsso_pkg::ONE_Q30 + $signed({10'd0, t0}) + t2;
  assign ramp_val = $signed({9'd0, p30, 1'b0}) - dc;

  always_comb begin
    case (region)
      bsso_pkg::RGN_MID: c0 = bsso_pkg::TWO_THIRDS_Q30;
      default:           c0 = -bsso_pkg::THIRD_Q30;
    endcase
  end

  // Additive term of each Horner step
  always_comb begin
    k_val = '0;
    case (region_r)
      bsso_pkg::RGN_HIGH: begin
        case (cmd.h_step)
          bsso_pkg::HSTEP_FIRST:  k_val = bsso_pkg::THREE_Q30;
          bsso_pkg::HSTEP_SECOND: k_val = t2 - bsso_pkg::NINE_Q30;
          default:                k_val = bsso_pkg::NINE_Q30 - dc;
        endcase
      end
      bsso_pkg::RGN_MID: begin
        case (cmd.h_step)
          bsso_pkg::HSTEP_FIRST:  k_val = -bsso_pkg::THREE_Q30;
          bsso_pkg::HSTEP_SECOND: k_val = t2 + bsso_pkg::THREE_Q30;
          default:                k_val = bsso_pkg::ONE_Q30 - dc;
        endcase
      end
      default: begin
        case (cmd.h_step)
          bsso_pkg::HSTEP_FIRST:  k_val = '0;
          bsso_pkg::HSTEP_SECOND: k_val = t2;
          default:                k_val = bsso_pkg::TWO_Q30 - dc;
        endcase
      end
    endcase
  end

  assign sts.poly = !cfg.waveform_mode && (region != bsso_pkg::RGN_RAMP);

  // ---- shared multiplier ----
  logic [bsso_pkg::MUL_X_BITS-1:0]                      mul_x;
  logic                                                 mul_neg;
  logic [bsso_pkg::MUL_B_BITS-1:0]                      mul_y;
  logic [bsso_pkg::MUL_A_BITS-1:0]                      mul_a;
  logic [bsso_pkg::MUL_A_BITS+bsso_pkg::MUL_B_BITS-1:0] mul_p;
  logic [bsso_pkg::PROD_BITS-1:0]                       prod;

  assign mul_a = cmd.mul_hi ? {8'd0, mul_x[39:24]} : mul_x[23:0];
  assign mul_p = mul_a * mul_y;

  // ---- accumulator ----
  logic signed [AB-1:0]          acc;
  logic [AB-1:0]                 acc_mag;
  logic [bsso_pkg::MAG_BITS-1:0] out_mag;
  logic [bsso_pkg::D_BITS-1:0]   d_val, d_r;
  logic [AB-1:0]                 h_term;

  assign acc_mag = acc[AB-1] ? AB'(-acc) : AB'(acc);
  assign out_mag = (acc_mag > bsso_pkg::Y_LIMIT) ? bsso_pkg::Y_LIMIT[32:0] : acc_mag[32:0];
  assign d_val   = (|prod[71:48]) ? '1 : prod[47:16];
  assign h_term  = prod[69:30];

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      region_r <= region;
      mul_x    <= {10'd0, p30};
      mul_neg  <= 1'b0;
      mul_y    <= cfg.reciprocal_increment;
      if (cfg.waveform_mode) begin
        acc <= (p32 >= cfg.pulse_width) ? bsso_pkg::HALF_Q30 : '0;
      end else if (region == bsso_pkg::RGN_RAMP) begin
        acc <= ramp_val;
      end else begin
        acc <= c0;
      end
    end
    if (cmd.mul_lo) begin
      prod <= {16'd0, mul_p};
    end
    if (cmd.mul_hi) begin
      prod <= prod + {mul_p[47:0], 24'd0};
    end
    if (cmd.take_d) begin
      d_r <= d_val;
    end
    if (cmd.h_setup) begin
      mul_x   <= acc_mag;
      mul_neg <= acc[AB-1];
      mul_y   <= d_r;
    end
    if (cmd.take_h) begin
      // truncation toward zero: subtract the magnitude for a negative factor
      acc <= mul_neg ? (k_val - $signed(h_term)) : (k_val + $signed(h_term));
    end
    if (cmd.out_setup) begin
      mul_x   <= {7'd0, out_mag};
      mul_neg <= acc[AB-1];
      mul_y   <= {16'd0, cfg.amplitude};
    end
  end

  // ---- output scaling: (P << (S-1)) - P is P times full scale ----
  logic [AMP_BITS-1:0]          amp_prod;
  logic [SCALE_BITS-1:0]        scaled;
  logic [R_BITS-1:0]            r_val, r_neg, pos_max, neg_max;
  logic [SAMPLE_BITS-1:0]       sample_next;

  assign amp_prod = prod[AMP_BITS-1:0];
  assign scaled   = {amp_prod, {(SAMPLE_BITS-1){1'b0}}} - SCALE_BITS'(amp_prod);
  assign r_val    = scaled[SCALE_BITS-1:45];
  assign r_neg    = -r_val;
  assign pos_max  = {4'd0, {(SAMPLE_BITS-1){1'b1}}};
  assign neg_max  = {3'd0, 1'b1, {(SAMPLE_BITS-1){1'b0}}};

  always_comb begin
    if (mul_neg) begin
      sample_next = (r_val > neg_max) ? neg_max[SAMPLE_BITS-1:0] : r_neg[SAMPLE_BITS-1:0];
    end else begin
      sample_next = (r_val > pos_max) ? pos_max[SAMPLE_BITS-1:0] : r_val[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample <= $signed(sample_next);
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

// File: hw/rtl/bandlimited_saw_square_oscillator_core.sv
// Top level of the band-limited sawtooth / square oscillator.
// Depends on bsso_pkg, bsso_if, bsso_ctrl and bsso_datapath.

// Each tick request advances a phase accumulator by phase_increment and
// yields one signed sample. Sawtooth mode (waveform_mode 0) wraps the phase
// and, within three increments of the wrap, replaces the ramp by a cubic in
// D = phase * reciprocal_increment, which keeps aliasing down; square mode
// resets the phase on overflow and outputs one half at or above pulse_width,
// else zero. The value is scaled by amplitude (Q1.15) times full scale and
// saturated. A tick request of zero is taken and produces no sample.
// Square mode and the plain ramp need only the gain product; in the
// transition region the single 24x32 multiplier, which needs two passes per
// product, forms one product for D, three for the Horner chain and one for
// the gain. The tick side is ready only while the sequencer is idle; a
// finished sample sits in the output register and the next tick is taken
// while it waits. Config writes are meant for when no request is in flight.
module bandlimited_saw_square_oscillator_core #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bsso_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bsso_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  bsso_tick_if.sink                             tick_chan,
  bsso_sample_if.source                         sample_chan
);

  bsso_pkg::cfg_t cfg;
  bsso_pkg::cmd_t cmd;
  bsso_pkg::sts_t sts;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform_mode        <= 1'b0;
      cfg.phase_increment      <= '0;
      cfg.reciprocal_increment <= '0;
      cfg.amplitude            <= '0;
      cfg.pulse_width          <= bsso_pkg::PULSE_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsso_pkg::CFG_WAVEFORM_MODE:        cfg.waveform_mode        <= cfg_data[0];
        bsso_pkg::CFG_PHASE_INCREMENT:      cfg.phase_increment      <= cfg_data[31:0];
        bsso_pkg::CFG_RECIPROCAL_INCREMENT: cfg.reciprocal_increment <= cfg_data[31:0];
        bsso_pkg::CFG_AMPLITUDE:            cfg.amplitude            <= cfg_data[15:0];
        bsso_pkg::CFG_PULSE_WIDTH:          cfg.pulse_width          <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer, one request at a time: classify, D/Horner if poly, scale.
  bsso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_chan.valid),
    .in_tick  (tick_chan.tick),
    .in_ready (tick_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and the output register.
  bsso_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (sample_chan.valid),
    .out_ready  (sample_chan.ready),
    .out_sample (sample_chan.sample)
  );

endmodule
